// ----- design/bsed_pkg.sv -----
// Shared types, constants and a helper function for the backslash escape decoder.
package bsed_pkg;

    // Default number of entries in the queue between the front and back parts.
    localparam int QueueDepth = 4;

    localparam int CharW = 8;

    // One queue entry holds every result caused by one input word.
    // An input word that causes no result pushes no entry.
    typedef struct packed {
        logic             two;    // second result present
        logic             stop0;  // first result is the stop marker
        logic [CharW-1:0] char0;
        logic [CharW-1:0] char1;
    } bsed_entry_t;

    // Queue status seen by the input handshake and the back part.
    typedef struct packed {
        logic full;
        logic empty;
    } bsed_qstat_t;

    // Decoded hex digit: bit 4 says the byte is a hex digit, bits 3:0 its value.
    function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- design/backslash_escape_decoder.sv -----
// Top level of the backslash escape decoder: front part, result queue and back part.
//
// The block decodes echo-style text one byte per input word. Input tdata carries an
// action code in bits 1:0 (data byte, end of argument, start of command) and the text
// byte in bits 9:2. With escapes enabled through the configuration channel, the usual
// backslash escapes, octal (\0nn) and hex (\xHH) values are decoded, and \c produces a
// single stop word (tuser set, tdata zero) after which input is dropped until a start of
// command. Each input word yields zero, one or two output words; tlast marks the final
// word caused by an input word. The front part takes one input word per clock cycle and
// updates the decode state in that cycle; its results go as one entry into a queue of
// QUEUE_DEPTH entries, and the back part drains the queue into an output register at one
// word per cycle while the receiver is ready. An input word with two results therefore
// gives two output words in turn, and input is only held off when the queue is full. With
// an empty queue, the first output word goes through a queue slot and then the output
// register after the edge that accepts the input word. Configuration writes are always
// taken and are meant to happen while no decoded words are outstanding.
module backslash_escape_decoder
#(
    parameter int QUEUE_DEPTH = bsed_pkg::QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: bit 0 is escapes_enabled.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] action, [9:2] char_in, [15:10] zero
    // Output words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_out
    output logic [0:0]  m_tuser,   // [0] stop_seen
    output logic        m_tlast
);

    bsed_pkg::bsed_entry_t push_entry;
    bsed_pkg::bsed_entry_t head;
    bsed_pkg::bsed_qstat_t qstat;
    logic                  push;
    logic                  pop;
    logic                  accept;
    logic                  stop_bit;

    assign cfg_ready = 1'b1;
    // The queue always has room for the entry of a word taken while it is not full.
    assign s_tready  = !qstat.full;
    assign accept    = s_tvalid && s_tready;

    bsed_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .action     (s_tdata[1:0]),
        .char_in    (s_tdata[9:2]),
        .push       (push),
        .push_entry (push_entry)
    );

    bsed_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (qstat)
    );

    bsed_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (qstat),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_char  (m_tdata),
        .out_stop  (stop_bit),
        .out_last  (m_tlast)
    );

    assign m_tuser = stop_bit;

    // A stop word is always the only word of its input word and carries a zero byte.
    a_stop_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
        else $error("stop word not alone or not zero");

    // The second word of a pair follows the first one right after it is taken.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser[0])
        else $error("second word of a pair missing");

    // Every push lands in the queue: the front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");

    // The back part never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule

// ----- design/bsed_front.sv -----
// Front part: accepts input words, runs the escape decoder state and queues the results.
module bsed_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_data,
    input  logic                       accept,
    input  logic [1:0]                 action,
    input  logic [bsed_pkg::CharW-1:0] char_in,
    output logic                       push,
    output bsed_pkg::bsed_entry_t      push_entry
);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_OCT    = 3'd2;
    localparam logic [2:0] MODE_HEX    = 3'd3;
    localparam logic [2:0] MODE_STOP   = 3'd4;

    localparam logic [1:0] ACT_DATA  = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    logic       esc_en_reg;
    logic [2:0] mode_reg, mode_next;
    logic [8:0] acc_reg, acc_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [1:0] n_res;
    logic [7:0] c0, c1;
    logic       s0;
    logic [7:0] pending;
    logic [8:0] acc_tmp;
    logic [1:0] cnt_tmp;
    logic [4:0] hv;

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        n_res     = 2'd0;
        c0        = char_in;
        c1        = char_in;
        s0        = 1'b0;
        hv        = bsed_pkg::hex_digit(char_in);
        pending   = (mode_reg == MODE_HEX && cnt_reg == 2'd0) ? CH_X : acc_reg[7:0];
        acc_tmp   = acc_reg;
        cnt_tmp   = cnt_reg + 2'd1;

        if (action == ACT_START)
        begin
            mode_next = MODE_NORMAL;
            acc_next  = '0;
            cnt_next  = '0;
        end
        else if (action == ACT_DATA || action == ACT_END)
        begin
            if (mode_reg == MODE_STOP)
            begin
                // Stopped: everything is dropped until a new command.
            end
            else if (!esc_en_reg)
            begin
                if (action == ACT_DATA)
                begin
                    n_res = 2'd1;
                end
            end
            else if (action == ACT_END)
            begin
                if (mode_reg == MODE_ESC)
                begin
                    n_res = 2'd1;
                    c0    = CH_BSLASH;
                end
                else if (mode_reg == MODE_OCT || mode_reg == MODE_HEX)
                begin
                    n_res = 2'd1;
                    c0    = pending;
                end
                mode_next = MODE_NORMAL;
                acc_next  = '0;
                cnt_next  = '0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_ESC:
                    begin
                        mode_next = MODE_NORMAL;
                        n_res     = 2'd1;
                        unique case (char_in)
                            8'h61:   c0 = 8'd7;
                            8'h62:   c0 = 8'd8;
                            8'h66:   c0 = 8'd12;
                            8'h6E:   c0 = 8'd10;
                            8'h72:   c0 = 8'd13;
                            8'h74:   c0 = 8'd9;
                            8'h76:   c0 = 8'd11;
                            8'h63:
                            begin
                                mode_next = MODE_STOP;
                                c0        = 8'd0;
                                s0        = 1'b1;
                            end
                            8'h30:
                            begin
                                mode_next = MODE_OCT;
                                acc_next  = '0;
                                cnt_next  = 2'd1;
                                n_res     = 2'd0;
                            end
                            CH_X:
                            begin
                                mode_next = MODE_HEX;
                                acc_next  = '0;
                                cnt_next  = 2'd0;
                                n_res     = 2'd0;
                            end
                            default: c0 = char_in;
                        endcase
                    end
                    MODE_OCT, MODE_HEX:
                    begin
                        if (mode_reg == MODE_OCT)
                        begin
                            acc_tmp = {acc_reg[5:0], 3'b000} + {6'b0, char_in[2:0]};
                        end
                        else
                        begin
                            acc_tmp = {acc_reg[4:0], hv[3:0]};
                        end
                        if ((mode_reg == MODE_OCT && char_in >= 8'h30 && char_in <= 8'h37
                             && cnt_reg < 2'd3)
                            || (mode_reg == MODE_HEX && hv[4] && cnt_reg < 2'd2))
                        begin
                            acc_next = acc_tmp;
                            cnt_next = cnt_tmp;
                            if ((mode_reg == MODE_OCT && cnt_tmp == 2'd3)
                                || (mode_reg == MODE_HEX && cnt_tmp == 2'd2))
                            begin
                                mode_next = MODE_NORMAL;
                                n_res     = 2'd1;
                                c0        = acc_tmp[7:0];
                            end
                        end
                        else
                        begin
                            // A non-digit flushes the value, then decodes as plain text.
                            c0 = pending;
                            if (char_in == CH_BSLASH)
                            begin
                                mode_next = MODE_ESC;
                                n_res     = 2'd1;
                            end
                            else
                            begin
                                mode_next = MODE_NORMAL;
                                n_res     = 2'd2;
                            end
                        end
                    end
                    default:
                    begin
                        if (char_in == CH_BSLASH)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else
                        begin
                            mode_next = MODE_NORMAL;
                            n_res     = 2'd1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_en_reg <= 1'b0;
            mode_reg   <= MODE_NORMAL;
            acc_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                esc_en_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    assign push             = accept && (n_res != 2'd0);
    assign push_entry.two   = (n_res == 2'd2);
    assign push_entry.stop0 = s0;
    assign push_entry.char0 = c0;
    assign push_entry.char1 = c1;

endmodule

// ----- design/bsed_fifo.sv -----
// Short queue of decoded result entries between the front and back parts.
module bsed_fifo
#(
    parameter int DEPTH = bsed_pkg::QueueDepth
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bsed_pkg::bsed_entry_t push_entry,
    input  logic                  pop,
    output bsed_pkg::bsed_entry_t head,
    output bsed_pkg::bsed_qstat_t stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    bsed_pkg::bsed_entry_t slots_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign stat.full  = (cnt_reg == CntW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- design/bsed_back.sv -----
// Back part: unpacks queued entries into single result words in an output register.
module bsed_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bsed_pkg::bsed_entry_t      head,
    input  bsed_pkg::bsed_qstat_t      stat,
    output logic                       pop,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [bsed_pkg::CharW-1:0] out_char,
    output logic                       out_stop,
    output logic                       out_last
);

    logic                       valid_reg;
    logic                       phase_reg;
    logic [bsed_pkg::CharW-1:0] char_reg;
    logic                       stop_reg;
    logic                       last_reg;
    logic                       load;
    logic                       first_of_two;

    assign load         = !stat.empty && (!valid_reg || out_ready);
    assign first_of_two = head.two && !phase_reg;
    assign pop          = load && !first_of_two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= first_of_two;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= phase_reg ? head.char1 : head.char0;
            stop_reg <= !phase_reg && head.stop0;
            last_reg <= !first_of_two;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_stop  = stop_reg;
    assign out_last  = last_reg;

endmodule

// ----- sim/bsed_output_checker.sv -----
// Stimulus codes shared by the test files, and the checker that predicts and compares output words.
package bsed_test_pkg;

    typedef enum logic [1:0] {
        ACT_DATA    = 2'd0,
        ACT_END_ARG = 2'd1,
        ACT_NEW_CMD = 2'd2,
        ACT_UNUSED  = 2'd3
    } action_e;

    localparam logic [7:0] CH_BSLASH = 8'h5c;

endpackage

module bsed_output_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        m_tlast,
    output int          error_count,
    output int          words_pending
);

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_AFTER_BSLASH,
        MODE_OCTAL,
        MODE_HEX,
        MODE_STOPPED
    } decode_mode_e;

    typedef struct packed {
        logic [7:0] char_out;
        logic       stop_seen;
        logic       last;
    } out_word_t;

    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_VT  = 8'h0b;
    localparam logic [7:0] CH_FF  = 8'h0c;
    localparam logic [7:0] CH_CR  = 8'h0d;

    out_word_t    expected_words[$];
    out_word_t    step_words[$];
    logic         escapes_on;
    decode_mode_e mode;
    logic [8:0]   value_acc;
    logic [1:0]   digit_cnt;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c - "a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    function automatic void emit(input logic [7:0] ch, input logic stop);
        step_words.push_back('{ch, stop, 1'b0});
    endfunction

    function automatic logic [7:0] pending_char();
        return (mode == MODE_HEX && digit_cnt == 2'd0) ? 8'("x") : value_acc[7:0];
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        if (c == bsed_test_pkg::CH_BSLASH)
        begin
            mode = MODE_AFTER_BSLASH;
        end
        else
        begin
            mode = MODE_PLAIN;
            emit(c, 1'b0);
        end
    endfunction

    function automatic void escaped_char(input logic [7:0] c);
        mode = MODE_PLAIN;
        case (c)
            "a": emit(CH_BEL, 1'b0);
            "b": emit(CH_BS, 1'b0);
            "f": emit(CH_FF, 1'b0);
            "n": emit(CH_LF, 1'b0);
            "r": emit(CH_CR, 1'b0);
            "t": emit(CH_TAB, 1'b0);
            "v": emit(CH_VT, 1'b0);
            "c":
            begin
                mode = MODE_STOPPED;
                emit(8'h00, 1'b1);
            end
            "0":
            begin
                mode      = MODE_OCTAL;
                value_acc = '0;
                digit_cnt = 2'd1;
            end
            "x":
            begin
                mode      = MODE_HEX;
                value_acc = '0;
                digit_cnt = 2'd0;
            end
            default: emit(c, 1'b0);
        endcase
    endfunction

    function automatic void data_char(input logic [7:0] c);
        int hv;
        case (mode)
            MODE_STOPPED: ;
            MODE_AFTER_BSLASH: escaped_char(c);
            MODE_OCTAL:
            begin
                if (c >= "0" && c <= "7" && digit_cnt < 2'd3)
                begin
                    value_acc = {value_acc[5:0], c[2:0]};
                    digit_cnt = digit_cnt + 2'd1;
                    if (digit_cnt == 2'd3)
                    begin
                        mode = MODE_PLAIN;
                        emit(value_acc[7:0], 1'b0);
                    end
                end
                else
                begin
                    emit(pending_char(), 1'b0);
                    plain_char(c);
                end
            end
            MODE_HEX:
            begin
                hv = nibble_of(c);
                if (hv >= 0 && digit_cnt < 2'd2)
                begin
                    value_acc = {value_acc[4:0], 4'(hv)};
                    digit_cnt = digit_cnt + 2'd1;
                    if (digit_cnt == 2'd2)
                    begin
                        mode = MODE_PLAIN;
                        emit(value_acc[7:0], 1'b0);
                    end
                end
                else
                begin
                    emit(pending_char(), 1'b0);
                    plain_char(c);
                end
            end
            default: plain_char(c);
        endcase
    endfunction

    function automatic void clear_decode();
        mode      = MODE_PLAIN;
        value_acc = '0;
        digit_cnt = 2'd0;
    endfunction

    function automatic void predict_word(input bsed_test_pkg::action_e act,
                                         input logic [7:0] c);
        step_words.delete();
        if (act == bsed_test_pkg::ACT_NEW_CMD)
        begin
            clear_decode();
        end
        else if (act != bsed_test_pkg::ACT_UNUSED && mode != MODE_STOPPED)
        begin
            if (!escapes_on)
            begin
                if (act == bsed_test_pkg::ACT_DATA)
                begin
                    emit(c, 1'b0);
                end
            end
            else if (act == bsed_test_pkg::ACT_DATA)
            begin
                data_char(c);
            end
            else
            begin
                if (mode == MODE_AFTER_BSLASH)
                begin
                    emit(bsed_test_pkg::CH_BSLASH, 1'b0);
                end
                else if (mode == MODE_OCTAL || mode == MODE_HEX)
                begin
                    emit(pending_char(), 1'b0);
                end
                clear_decode();
            end
        end
        if (step_words.size() > 0)
        begin
            step_words[step_words.size() - 1].last = 1'b1;
        end
        foreach (step_words[i])
        begin
            expected_words.push_back(step_words[i]);
        end
    endfunction

    function automatic void check_word();
        out_word_t want;
        if (expected_words.size() == 0)
        begin
            $error("unexpected output word: char_out %02h stop_seen %0b last %0b",
                   m_tdata, m_tuser[0], m_tlast);
            error_count++;
            return;
        end
        want = expected_words.pop_front();
        if (m_tdata !== want.char_out)
        begin
            $error("char_out: expected %02h, got %02h", want.char_out, m_tdata);
            error_count++;
        end
        if (m_tuser[0] !== want.stop_seen)
        begin
            $error("stop_seen: expected %0b, got %0b", want.stop_seen, m_tuser[0]);
            error_count++;
        end
        if (m_tlast !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escapes_on = 1'b0;
            clear_decode();
            expected_words.delete();
            error_count   = 0;
            words_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                escapes_on = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                predict_word(bsed_test_pkg::action_e'(s_tdata[1:0]), s_tdata[9:2]);
            end
            if (m_tvalid && m_tready)
            begin
                check_word();
            end
            words_pending = expected_words.size();
        end
    end

endmodule

// ----- sim/backslash_escape_decoder_test.sv -----
// Top of the backslash escape decoder test: clock, reset, stimulus, stalls and verdict.
module backslash_escape_decoder_test;

    // Rough number of input words over the whole run, and how long the
    // receiver holds off in the backpressure test.
    localparam int ITEM_TARGET   = 1700;
    localparam int RANDOM_PHASES = 8;
    localparam int HOLD_CYCLES   = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [1:0] action, [9:2] char_in, [15:10] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] char_out
    logic [0:0]  m_tuser;   // [0] stop_seen
    logic        m_tlast;

    int error_count;
    int words_pending;
    int items_sent;

    // Idling controls: the sender and the receiver each insert random bursts
    // of idle cycles while their flag is set. A hold request makes the
    // receiver stall for a long stretch, counted in its own process.
    bit sender_gaps;
    bit receiver_gaps;
    bit hold_req;

    // Escape letters that the random part favors after a backslash; the last
    // two are the escaped backslash and a letter with no special meaning.
    logic [7:0] esc_letters [9] = '{"a", "b", "f", "n", "r", "t", "v", "\\", "q"};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    backslash_escape_decoder DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    bsed_output_checker out_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    // Offer one input word from a falling edge, hold it until the block takes
    // it, and return at the falling edge after the handshake. The caller is
    // left with tvalid still high; the next word or an idle step replaces it.
    task automatic send_word(input bsed_test_pkg::action_e act, input logic [7:0] c);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, c, act};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(bsed_test_pkg::ACT_DATA, s[i]);
        end
    endtask

    // A value is only written to the escape setting once every decoded word
    // has come out. Words that decode to nothing leave no trace in the
    // pending count, so the task also waits out the queue and output register.
    task automatic write_escapes(input logic enable);
        s_tvalid = 1'b0;
        while (words_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = enable;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] random_hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'("0" + v);
        end
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    // One random token of text. Nearly half are well formed escape sequences
    // with random content, so that the octal and hex paths and the stop state
    // are visited often; the rest are plain bytes, argument and command
    // marks, the unused action code, and stray digits.
    task automatic send_token();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            send_word(bsed_test_pkg::ACT_DATA, 8'($urandom_range(0, 255)));
        end
        else if (kind < 48)
        begin
            send_word(bsed_test_pkg::ACT_DATA, bsed_test_pkg::CH_BSLASH);
            if ($urandom_range(0, 2) == 0)
            begin
                send_word(bsed_test_pkg::ACT_DATA, 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_word(bsed_test_pkg::ACT_DATA, esc_letters[$urandom_range(0, 8)]);
            end
        end
        else if (kind < 60)
        begin
            // Octal value: the leading 0 and up to three more digits, so the
            // digit limit is hit and overrun as well as cut short.
            send_text("\\0");
            n = $urandom_range(0, 3);
            repeat (n) send_word(bsed_test_pkg::ACT_DATA, 8'("0" + $urandom_range(0, 7)));
            if ($urandom_range(0, 1))
            begin
                send_word(bsed_test_pkg::ACT_DATA, 8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 72)
        begin
            send_text("\\x");
            n = $urandom_range(0, 3);
            repeat (n) send_word(bsed_test_pkg::ACT_DATA, random_hex_digit());
            if ($urandom_range(0, 1))
            begin
                send_word(bsed_test_pkg::ACT_DATA, 8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 80)
        begin
            if ($urandom_range(0, 1))
            begin
                send_word(bsed_test_pkg::ACT_DATA, bsed_test_pkg::CH_BSLASH);
            end
            send_word(bsed_test_pkg::ACT_END_ARG, 8'($urandom_range(0, 255)));
        end
        else if (kind < 85)
        begin
            // Stop marker, some input that must be dropped, and usually a new
            // command to leave the stopped state again.
            send_text("\\c");
            repeat ($urandom_range(0, 3))
                send_word(bsed_test_pkg::ACT_DATA, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
            begin
                send_word(bsed_test_pkg::ACT_END_ARG, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                send_word(bsed_test_pkg::ACT_NEW_CMD, 8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 92)
        begin
            send_word(bsed_test_pkg::ACT_NEW_CMD, 8'($urandom_range(0, 255)));
        end
        else if (kind < 95)
        begin
            send_word(bsed_test_pkg::ACT_UNUSED, 8'($urandom_range(0, 255)));
        end
        else
        begin
            send_word(bsed_test_pkg::ACT_DATA, 8'("0" + $urandom_range(0, 9)));
        end
    endtask

    // Receiver: ready by default, with random stall bursts while enabled, and
    // one long hold-off on request so that the result queue fills and the
    // input side is stalled.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready = 1'b1;
            end
            else if (receiver_gaps && $urandom_range(0, 4) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                m_tready = 1'b1;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("backslash_escape_decoder_test: done, errors");
        $finish;
    end

    initial
    begin
        int phase_end;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        hold_req      = 1'b0;
        items_sent    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Escapes are off after reset: bytes pass through unchanged, the
        // extremes and a backslash included, and the marks give nothing.
        send_word(bsed_test_pkg::ACT_DATA, 8'h00);
        send_word(bsed_test_pkg::ACT_DATA, 8'h01);
        send_word(bsed_test_pkg::ACT_DATA, 8'hff);
        send_text("\\n");
        send_word(bsed_test_pkg::ACT_END_ARG, 8'h55);
        send_word(bsed_test_pkg::ACT_UNUSED, 8'haa);
        send_word(bsed_test_pkg::ACT_NEW_CMD, 8'hff);

        // Long receiver hold-off while the sender keeps going back to back.
        hold_req = 1'b1;
        repeat (40) send_word(bsed_test_pkg::ACT_DATA, 8'($urandom_range(0, 255)));

        write_escapes(1'b1);

        // Directed escapes: a control letter, escaped backslash, an unknown
        // letter and byte 255 after a backslash, an octal value that hits
        // the digit limit, octal and hex cut short by a non-digit, a bare \x,
        // flushes at the end of an argument, and the stop marker with input
        // dropped until a new command.
        send_text("\\n\\\\\\q");
        send_word(bsed_test_pkg::ACT_DATA, bsed_test_pkg::CH_BSLASH);
        send_word(bsed_test_pkg::ACT_DATA, 8'hff);
        send_text("\\0101\\07z\\08\\x4g\\xg\\x4\\");
        send_word(bsed_test_pkg::ACT_END_ARG, 8'h00);
        send_text("\\x");
        send_word(bsed_test_pkg::ACT_UNUSED, 8'h31);
        send_word(bsed_test_pkg::ACT_END_ARG, 8'h00);
        send_word(bsed_test_pkg::ACT_DATA, bsed_test_pkg::CH_BSLASH);
        send_word(bsed_test_pkg::ACT_END_ARG, 8'h00);
        send_text("\\04");
        send_word(bsed_test_pkg::ACT_END_ARG, 8'h00);
        send_text("\\ck");
        send_word(bsed_test_pkg::ACT_END_ARG, 8'h00);
        send_word(bsed_test_pkg::ACT_NEW_CMD, 8'h00);
        send_text("\\0m");

        // Random phases, each under its own escape setting and idling mix.
        // The final phase runs with no idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_escapes(phase % 3 != 2);
            sender_gaps   = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            receiver_gaps = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            phase_end     = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - phase);
            while (items_sent < phase_end)
            begin
                send_token();
            end
        end

        s_tvalid = 1'b0;
        while (words_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);

        if (error_count == 0 && words_pending == 0)
        begin
            $display("backslash_escape_decoder_test: done, clean");
        end
        else
        begin
            $display("backslash_escape_decoder_test: done, errors");
        end
        $finish;
    end

endmodule
